### rtl/vpr_pkg.sv
// shared constants, quadrant codes and the trig table series for the phase rotator
package vpr_pkg;

   localparam int DATA_W        = 32;
   localparam int PHASE_BITS    = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int SERIES_TERMS  = 12;
   localparam int Q30_FRAC      = 30;
   localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

   typedef enum logic [0:0] {
      REG_SHIFT_RATE_X = 1'b0,
      REG_SHIFT_RATE_Y = 1'b1
   } csr_reg_type;

   typedef enum logic [1:0] {
      QUAD_FIRST  = 2'd0,
      QUAD_SECOND = 2'd1,
      QUAD_THIRD  = 2'd2,
      QUAD_FOURTH = 2'd3
   } quad_type;

   // unsigned long division for the series terms
   function automatic longint unsigned div_u64(input longint unsigned num,
                                               input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      begin
         quo = '0;
         rem = '0;
         for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
               rem    = rem - den;
               quo[b] = 1'b1;
            end
         end
         return quo;
      end
   endfunction

   // quarter-wave sine entry k in unsigned q0.frac_bits, integer q30 power series
   function automatic longint unsigned trig_entry(input int k, input int addr_bits,
                                                  input int frac_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned e;
      longint unsigned maxval;
      longint          sum;
      begin
         maxval = (64'd1 << frac_bits) - 64'd1;
         x      = (Q30_HALF_PI * longint'(unsigned'(k))) >> addr_bits;
         x2     = (x * x) >> Q30_FRAC;
         term   = x;
         sum    = longint'(x);
         for (int n = 1; n <= SERIES_TERMS; n++) begin
            term = div_u64((term * x2) >> Q30_FRAC,
                           longint'(unsigned'((2 * n) * (2 * n + 1))));
            if ((n & 1) == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         e = (longint'(sum) + (64'd1 << (Q30_FRAC - frac_bits - 1))) >> (Q30_FRAC - frac_bits);
         if (e > maxval) begin
            e = maxval;
         end
         return e;
      end
   endfunction

endpackage

### rtl/vpr_trig_rom.sv
// quarter-wave sine rom with two registered read ports
module vpr_trig_rom import vpr_pkg::*; #(
   parameter int ADDR_BITS  = 10,
   parameter int ENTRY_BITS = 15
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [ADDR_BITS:0]    addr_a,
   input  logic [ADDR_BITS:0]    addr_b,
   output logic [ENTRY_BITS-1:0] data_a,
   output logic [ENTRY_BITS-1:0] data_b
);

   localparam int DEPTH = (1 << ADDR_BITS) + 1;

   typedef logic [ENTRY_BITS-1:0] rom_type [0:DEPTH-1];

   function automatic rom_type build_rom();
      rom_type r;
      begin
         for (int k = 0; k < DEPTH; k++) begin
            r[k] = ENTRY_BITS'(trig_entry(k, ADDR_BITS, ENTRY_BITS));
         end
         return r;
      end
   endfunction

   localparam rom_type ROM_DATA = build_rom();

   logic [ENTRY_BITS-1:0] data_a_ff;
   logic [ENTRY_BITS-1:0] data_b_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_a_ff <= ROM_DATA[addr_a];
         data_b_ff <= ROM_DATA[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

### rtl/visibility_phase_rotator_unit.sv
// visibility phase rotator top level: csr, phase pipeline and complex rotation
// six register stages: phase products, table read, quadrant select, rotation
// products, sums, round and saturate. one transfer per cycle sustained while
// rsp_stall is low, set by the pipelined multipliers and the two-port table
// read; bubbles are squeezed out under stall. synchronous reset clears the valid
// bits and both shift rate registers.
module visibility_phase_rotator_unit import vpr_pkg::*; #(
   parameter int TABLE_ADDR_BITS = 10,
   parameter int TRIG_BITS       = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DATA_W-1:0]     req_coord_u,
   input  logic [DATA_W-1:0]     req_coord_v,
   input  logic [DATA_W-1:0]     req_vis_real,
   input  logic [DATA_W-1:0]     req_vis_imag,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_W-1:0]     rsp_rot_real,
   output logic [DATA_W-1:0]     rsp_rot_imag,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready
);

   localparam int A  = TABLE_ADDR_BITS;
   localparam int TW = TRIG_BITS;
   localparam int EW = TRIG_BITS - 1;
   localparam int PW = DATA_W + TW;
   localparam int SW = PW + 1;
   localparam int RW = SW + 1;
   localparam int QW = RW - EW;

   localparam logic [A:0]           QUARTER_LEN = (A + 1)'(64'd1 << A);
   localparam logic signed [RW-1:0] ROUND_HALF  = RW'(64'd1 << (EW - 1));
   localparam logic signed [QW-1:0] SAT_MAX     = QW'(64'sd2147483647);
   localparam logic signed [QW-1:0] SAT_MIN     = QW'(-64'sd2147483648);

   // csr
   logic [DATA_W-1:0] shift_rate_x_ff;
   logic [DATA_W-1:0] shift_rate_y_ff;
   csr_reg_type       csr_sel;

   assign csr_sel = csr_reg_type'(paddr[2]);
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_rate_x_ff <= '0;
         shift_rate_y_ff <= '0;
      end else if (psel && penable && pwrite && pready) begin
         unique case (csr_sel)
            REG_SHIFT_RATE_X: shift_rate_x_ff <= pwdata;
            REG_SHIFT_RATE_Y: shift_rate_y_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_sel)
         REG_SHIFT_RATE_X: prdata = shift_rate_x_ff;
         REG_SHIFT_RATE_Y: prdata = shift_rate_y_ff;
         default:          prdata = '0;
      endcase
   end

   // stage enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5, en6;

   assign en6       = !rsp_valid_ff || !rsp_stall;
   assign en5       = !s5_valid_ff || en6;
   assign en4       = !s4_valid_ff || en5;
   assign en3       = !s3_valid_ff || en4;
   assign en2       = !s2_valid_ff || en3;
   assign en1       = !s1_valid_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff  <= req_valid;
         if (en2) s2_valid_ff  <= s1_valid_ff;
         if (en3) s3_valid_ff  <= s2_valid_ff;
         if (en4) s4_valid_ff  <= s3_valid_ff;
         if (en5) s5_valid_ff  <= s4_valid_ff;
         if (en6) rsp_valid_ff <= s5_valid_ff;
      end
   end

   // stage 1: phase products, low word only
   logic [PHASE_BITS-1:0] s1_pu_ff, s1_pv_ff;
   logic [DATA_W-1:0]     s1_re_ff, s1_im_ff;
   logic [2*DATA_W-1:0]   pu_full, pv_full;

   assign pu_full = req_coord_u * shift_rate_x_ff;
   assign pv_full = req_coord_v * shift_rate_y_ff;

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_pu_ff <= pu_full[PHASE_BITS-1:0];
         s1_pv_ff <= pv_full[PHASE_BITS-1:0];
         s1_re_ff <= req_vis_real;
         s1_im_ff <= req_vis_imag;
      end
   end

   // stage 2: phase word and table read
   logic [PHASE_BITS-1:0] phase;
   logic [A:0]            addr_s, addr_c;
   logic [EW-1:0]         s0_rd, c0_rd;
   quad_type              s2_quad_ff;
   logic [DATA_W-1:0]     s2_re_ff, s2_im_ff;

   assign phase  = PHASE_BITS'(0) - (s1_pu_ff + s1_pv_ff);
   assign addr_s = {1'b0, phase[PHASE_BITS-3 -: A]};
   assign addr_c = QUARTER_LEN - addr_s;

   vpr_trig_rom #(
      .ADDR_BITS  (A),
      .ENTRY_BITS (EW)
   ) u_trig_rom (
      .clock  (clock),
      .rd_en  (en2),
      .addr_a (addr_s),
      .addr_b (addr_c),
      .data_a (s0_rd),
      .data_b (c0_rd)
   );

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_quad_ff <= quad_type'(phase[PHASE_BITS-1 -: 2]);
         s2_re_ff   <= s1_re_ff;
         s2_im_ff   <= s1_im_ff;
      end
   end

   // stage 3: quadrant fold
   logic signed [TW-1:0]     s0_val, c0_val, sin_in, cos_in;
   logic signed [TW-1:0]     s3_sin_ff, s3_cos_ff;
   logic signed [DATA_W-1:0] s3_re_ff, s3_im_ff;

   assign s0_val = signed'({1'b0, s0_rd});
   assign c0_val = signed'({1'b0, c0_rd});

   always_comb begin
      case (s2_quad_ff)
         QUAD_FIRST:  begin sin_in = s0_val;  cos_in = c0_val;  end
         QUAD_SECOND: begin sin_in = c0_val;  cos_in = -s0_val; end
         QUAD_THIRD:  begin sin_in = -s0_val; cos_in = -c0_val; end
         default:     begin sin_in = -c0_val; cos_in = s0_val;  end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_sin_ff <= sin_in;
         s3_cos_ff <= cos_in;
         s3_re_ff  <= signed'(s2_re_ff);
         s3_im_ff  <= signed'(s2_im_ff);
      end
   end

   // stage 4: rotation products
   logic signed [PW-1:0] s4_cr_ff, s4_si_ff, s4_ci_ff, s4_sr_ff;

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_cr_ff <= PW'(s3_cos_ff) * PW'(s3_re_ff);
         s4_si_ff <= PW'(s3_sin_ff) * PW'(s3_im_ff);
         s4_ci_ff <= PW'(s3_cos_ff) * PW'(s3_im_ff);
         s4_sr_ff <= PW'(s3_sin_ff) * PW'(s3_re_ff);
      end
   end

   // stage 5: sums
   logic signed [SW-1:0] s5_sum_r_ff, s5_sum_i_ff;

   always_ff @(posedge clock) begin
      if (en5) begin
         s5_sum_r_ff <= SW'(s4_cr_ff) - SW'(s4_si_ff);
         s5_sum_i_ff <= SW'(s4_ci_ff) + SW'(s4_sr_ff);
      end
   end

   // stage 6: round half up and saturate
   logic signed [RW-1:0] rnd_r, rnd_i;
   logic signed [QW-1:0] q_r, q_i;
   logic [DATA_W-1:0]    rot_real_in, rot_imag_in;
   logic [DATA_W-1:0]    rot_real_ff, rot_imag_ff;

   assign rnd_r = RW'(s5_sum_r_ff) + ROUND_HALF;
   assign rnd_i = RW'(s5_sum_i_ff) + ROUND_HALF;
   assign q_r   = QW'(rnd_r >>> EW);
   assign q_i   = QW'(rnd_i >>> EW);

   assign rot_real_in = (q_r > SAT_MAX) ? SAT_MAX[DATA_W-1:0] :
                        (q_r < SAT_MIN) ? SAT_MIN[DATA_W-1:0] : q_r[DATA_W-1:0];
   assign rot_imag_in = (q_i > SAT_MAX) ? SAT_MAX[DATA_W-1:0] :
                        (q_i < SAT_MIN) ? SAT_MIN[DATA_W-1:0] : q_i[DATA_W-1:0];

   always_ff @(posedge clock) begin
      if (en6) begin
         rot_real_ff <= rot_real_in;
         rot_imag_ff <= rot_imag_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_rot_real = rot_real_ff;
   assign rsp_rot_imag = rot_imag_ff;

endmodule
